@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/eso3_pkg.sv @@
// ----------------------------------------------------------------------------
// eso3_pkg
// Widths, register indexes, types and codes of the third-order observer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eso3_pkg;

   // field widths
   localparam int CUR_W      = 32;
   localparam int ANGLE_W    = 48;
   localparam int STATE_W    = 48;
   localparam int GAIN_W     = 48;
   localparam int STEP_W     = 32;
   localparam int LEAK_W     = 32;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 144;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_POSITION    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_SPEED       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_DISTURBANCE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_INPUT_GAIN       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TIME_STEP        = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_LEAK_RATE        = 3'd5;

   localparam logic [STEP_W-1:0] TIME_STEP_RESET = 32'd4294967;

   // friction current is compensated only when its magnitude is above 65 LSB (about 1 mA)
   localparam logic signed [CUR_W-1:0] FRICTION_HI = 32'sd65;
   localparam logic signed [CUR_W-1:0] FRICTION_LO = -32'sd65;

   // datapath widths
   localparam int ERR_W   = 49;   // z1 - y
   localparam int UCOR_W  = 33;   // corrected current
   localparam int SUM_W   = 62;   // intermediate sums
   localparam int MAG_W   = 61;   // multiplicand magnitude
   localparam int MUL_B_W = 48;   // serial multiplier operand
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = MUL_B_W / DIGIT_W;
   localparam int CNT_W   = $clog2(DIGITS);
   localparam int PROD_W  = MAG_W + MUL_B_W;
   localparam int TERM_W  = 59;   // saturated product magnitude
   localparam int FINE_SHIFT  = 16;
   localparam int COARSE_SHIFT = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_OUT
   } state_type;

   // multiply sequence, in issue order
   typedef enum logic [2:0] {
      OP_BETA1_ERR,
      OP_BETA2_ERR,
      OP_B0_CUR,
      OP_BETA3_ERR,
      OP_ETA_Z3,
      OP_DT_R1,
      OP_DT_R2,
      OP_DT_R3
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

@@ rtl/core/eso3_mul.sv @@
// ----------------------------------------------------------------------------
// eso3_mul
// Digit-serial unsigned multiplier: parallel multiplicand, 4-bit digits of
// the multiplier per cycle, product shifted out into the multiplier register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eso3_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [eso3_pkg::MAG_W-1:0]      a_mag,
   input  logic [eso3_pkg::MUL_B_W-1:0]    b_val,
   output eso3_pkg::mul_status_type        status,
   output logic [eso3_pkg::PROD_W-1:0]     product
);

   localparam int SUM_W = eso3_pkg::MAG_W + eso3_pkg::DIGIT_W;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [eso3_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [eso3_pkg::MAG_W-1:0]      a_ff, a_in;
   logic [eso3_pkg::MAG_W-1:0]      acc_ff, acc_in;
   logic [eso3_pkg::MUL_B_W-1:0]    b_ff, b_in;
   logic [SUM_W-1:0]                digit_sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;

      digit_sum = {{eso3_pkg::DIGIT_W{1'b0}}, acc_ff};
      for (int i = 0; i < eso3_pkg::DIGIT_W; i++) begin
         if (b_ff[i]) begin
            digit_sum = digit_sum + ({{eso3_pkg::DIGIT_W{1'b0}}, a_ff} << i);
         end
      end

      priority if (start) begin
         a_in    = a_mag;
         b_in    = b_val;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // low digit of the partial sum becomes a final product digit
         acc_in = digit_sum[SUM_W-1:eso3_pkg::DIGIT_W];
         b_in   = {digit_sum[eso3_pkg::DIGIT_W-1:0],
                   b_ff[eso3_pkg::MUL_B_W-1:eso3_pkg::DIGIT_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == eso3_pkg::CNT_W'(eso3_pkg::DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
   end

   assign status  = '{busy: busy_ff, done: done_ff};
   assign product = {acc_ff, b_ff};

endmodule

@@ rtl/core/eso_third_order_observer.sv @@
// ----------------------------------------------------------------------------
// eso_third_order_observer
// Third-order linear extended state observer, one forward Euler step per beat.
// ----------------------------------------------------------------------------
// Input beat (req_): drive current, measured angle and friction current. Each
// accepted beat advances the position, speed and disturbance estimates by one
// control period and yields one result beat (rsp_) with all three new values.
// The user writes gains, plant gain, time step and leak rate on csr_ while
// idle; the block itself does not enforce this.
//
// Eight multiplies run one after another on a single digit-serial multiplier
// (61-bit multiplicand, 4 multiplier bits per cycle, 12 digits), each with
// operand load and accumulate. A new input beat is taken only once the last
// result has been handed to the output register.
//
// The result sits in an output register, so req_tready returns as soon as the
// result is handed to it. If rsp_tready stays low, the next item is still
// taken and computed but waits before its result is written out.
//
// Reset clears the estimates to zero, loads the register defaults (time step
// about 1 ms, all else zero) and drops rsp_tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eso_third_order_observer (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: drive_current[31:0], measured_angle[79:32], friction_current[111:80]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [eso3_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tdata: angle_estimate[47:0], speed_estimate[95:48],
   //        disturbance_estimate[143:96]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [eso3_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [eso3_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [eso3_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SUM_W   = eso3_pkg::SUM_W;
   localparam int STATE_W = eso3_pkg::STATE_W;
   localparam int TERM_W  = eso3_pkg::TERM_W;
   localparam int FINE_LO = eso3_pkg::FINE_SHIFT;
   localparam int COARSE_LO = eso3_pkg::COARSE_SHIFT;

   // configuration
   logic [eso3_pkg::GAIN_W-1:0]  gain_pos_ff, gain_pos_in;
   logic [eso3_pkg::GAIN_W-1:0]  gain_spd_ff, gain_spd_in;
   logic [eso3_pkg::GAIN_W-1:0]  gain_dist_ff, gain_dist_in;
   logic [eso3_pkg::GAIN_W-1:0]  input_gain_ff, input_gain_in;
   logic [eso3_pkg::STEP_W-1:0]  time_step_ff, time_step_in;
   logic [eso3_pkg::LEAK_W-1:0]  leak_rate_ff, leak_rate_in;

   // control
   eso3_pkg::state_type          state_ff, state_in;
   eso3_pkg::op_type             op_ff, op_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // estimates
   logic [STATE_W-1:0]           z1_ff, z1_in;
   logic [STATE_W-1:0]           z2_ff, z2_in;
   logic [STATE_W-1:0]           z3_ff, z3_in;

   // datapath payload
   logic [eso3_pkg::ERR_W-1:0]   err_ff, err_in;
   logic [eso3_pkg::UCOR_W-1:0]  cur_ff, cur_in;
   logic [SUM_W-1:0]             r1_ff, r1_in;
   logic [SUM_W-1:0]             r2_ff, r2_in;
   logic [SUM_W-1:0]             r3_ff, r3_in;
   logic                         neg_ff, neg_in;
   logic [eso3_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [eso3_pkg::CUR_W-1:0]   drive_current;
   logic [eso3_pkg::ANGLE_W-1:0] measured_angle;
   logic [eso3_pkg::CUR_W-1:0]   friction_current;
   logic                         friction_on;

   // multiplier hookup
   logic                         mul_start;
   logic [eso3_pkg::MAG_W-1:0]   mul_a;
   logic [eso3_pkg::MUL_B_W-1:0] mul_b;
   eso3_pkg::mul_status_type     mul_st;
   logic [eso3_pkg::PROD_W-1:0]  mul_prod;

   // operand and term
   logic [SUM_W-1:0]             opnd;
   logic [SUM_W-1:0]             opnd_abs;
   logic                         coarse;
   logic                         term_over;
   logic [TERM_W-1:0]            term_mag;
   logic [SUM_W-1:0]             term;
   logic                         rsp_load;

   function automatic logic [STATE_W-1:0] sat_state(input logic [SUM_W-1:0] v);
      logic [SUM_W-STATE_W:0] top;
      top = v[SUM_W-1:STATE_W-1];
      if ((&top) || !(|top)) begin
         return v[STATE_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   assign drive_current    = req_tdata[31:0];
   assign measured_angle   = req_tdata[79:32];
   assign friction_current = req_tdata[111:80];

   assign friction_on = ($signed(friction_current) > eso3_pkg::FRICTION_HI) ||
                        ($signed(friction_current) < eso3_pkg::FRICTION_LO);

   // configuration writes
   always_comb begin
      gain_pos_in   = gain_pos_ff;
      gain_spd_in   = gain_spd_ff;
      gain_dist_in  = gain_dist_ff;
      input_gain_in = input_gain_ff;
      time_step_in  = time_step_ff;
      leak_rate_in  = leak_rate_ff;
      if (csr_we) begin
         unique case (csr_addr)
            eso3_pkg::REG_GAIN_POSITION:    gain_pos_in   = csr_wdata;
            eso3_pkg::REG_GAIN_SPEED:       gain_spd_in   = csr_wdata;
            eso3_pkg::REG_GAIN_DISTURBANCE: gain_dist_in  = csr_wdata;
            eso3_pkg::REG_INPUT_GAIN:       input_gain_in = csr_wdata;
            eso3_pkg::REG_TIME_STEP:
               time_step_in = csr_wdata[eso3_pkg::STEP_W-1:0];
            eso3_pkg::REG_LEAK_RATE:
               leak_rate_in = csr_wdata[eso3_pkg::LEAK_W-1:0];
            default: ;
         endcase
      end
   end

   // operands for the current multiply; the signed one is sign-extended to the sum width
   always_comb begin
      unique case (op_ff)
         eso3_pkg::OP_BETA1_ERR,
         eso3_pkg::OP_BETA2_ERR,
         eso3_pkg::OP_BETA3_ERR: begin
            opnd = {{(SUM_W-eso3_pkg::ERR_W){err_ff[eso3_pkg::ERR_W-1]}}, err_ff};
         end
         eso3_pkg::OP_B0_CUR: begin
            opnd = {{(SUM_W-eso3_pkg::UCOR_W){cur_ff[eso3_pkg::UCOR_W-1]}}, cur_ff};
         end
         eso3_pkg::OP_ETA_Z3: begin
            opnd = {{(SUM_W-STATE_W){z3_ff[STATE_W-1]}}, z3_ff};
         end
         eso3_pkg::OP_DT_R1: opnd = r1_ff;
         eso3_pkg::OP_DT_R2: opnd = r2_ff;
         eso3_pkg::OP_DT_R3: opnd = r3_ff;
      endcase

      unique case (op_ff)
         eso3_pkg::OP_BETA1_ERR: mul_b = gain_pos_ff;
         eso3_pkg::OP_BETA2_ERR: mul_b = gain_spd_ff;
         eso3_pkg::OP_B0_CUR:    mul_b = input_gain_ff;
         eso3_pkg::OP_BETA3_ERR: mul_b = gain_dist_ff;
         eso3_pkg::OP_ETA_Z3: begin
            mul_b = {{(eso3_pkg::MUL_B_W-eso3_pkg::LEAK_W){1'b0}}, leak_rate_ff};
         end
         eso3_pkg::OP_DT_R1,
         eso3_pkg::OP_DT_R2,
         eso3_pkg::OP_DT_R3: begin
            mul_b = {{(eso3_pkg::MUL_B_W-eso3_pkg::STEP_W){1'b0}}, time_step_ff};
         end
      endcase

      opnd_abs = opnd[SUM_W-1] ? (SUM_W'(0) - opnd) : opnd;
      mul_a    = opnd_abs[eso3_pkg::MAG_W-1:0];
   end

   // truncate the product magnitude, saturate, then apply the sign
   always_comb begin
      coarse = (op_ff == eso3_pkg::OP_DT_R1) || (op_ff == eso3_pkg::OP_DT_R2) ||
               (op_ff == eso3_pkg::OP_DT_R3);
      if (coarse) begin
         term_over = |mul_prod[eso3_pkg::PROD_W-1:COARSE_LO+TERM_W];
         term_mag  = mul_prod[COARSE_LO+TERM_W-1:COARSE_LO];
      end else begin
         term_over = |mul_prod[eso3_pkg::PROD_W-1:FINE_LO+TERM_W];
         term_mag  = mul_prod[FINE_LO+TERM_W-1:FINE_LO];
      end
      if (term_over) begin
         term_mag = '1;
      end
      term = neg_ff ? (SUM_W'(0) - {{(SUM_W-TERM_W){1'b0}}, term_mag})
                    : {{(SUM_W-TERM_W){1'b0}}, term_mag};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      cur_in       = cur_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      z3_in        = z3_ff;
      neg_in       = neg_ff;
      req_tready   = 1'b0;
      mul_start    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         eso3_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               err_in = {z1_ff[STATE_W-1], z1_ff} -
                        {measured_angle[eso3_pkg::ANGLE_W-1], measured_angle};
               cur_in = friction_on ?
                        ({drive_current[eso3_pkg::CUR_W-1], drive_current} -
                         {friction_current[eso3_pkg::CUR_W-1], friction_current}) :
                        {drive_current[eso3_pkg::CUR_W-1], drive_current};
               op_in    = eso3_pkg::OP_BETA1_ERR;
               state_in = eso3_pkg::ST_LOAD;
            end
         end
         eso3_pkg::ST_LOAD: begin
            mul_start = 1'b1;
            neg_in    = opnd[SUM_W-1];
            state_in  = eso3_pkg::ST_MUL;
         end
         eso3_pkg::ST_MUL: begin
            if (mul_st.done) begin
               unique case (op_ff)
                  eso3_pkg::OP_BETA1_ERR:
                     r1_in = {{(SUM_W-STATE_W){z2_ff[STATE_W-1]}}, z2_ff} - term;
                  eso3_pkg::OP_BETA2_ERR:
                     r2_in = {{(SUM_W-STATE_W){z3_ff[STATE_W-1]}}, z3_ff} - term;
                  eso3_pkg::OP_B0_CUR:    r2_in = r2_ff + term;
                  eso3_pkg::OP_BETA3_ERR: r3_in = SUM_W'(0) - term;
                  eso3_pkg::OP_ETA_Z3:    r3_in = r3_ff - term;
                  // z1 and z2 are not read again in this step once updated
                  eso3_pkg::OP_DT_R1: z1_in = sat_state(
                     {{(SUM_W-STATE_W){z1_ff[STATE_W-1]}}, z1_ff} + term);
                  eso3_pkg::OP_DT_R2: z2_in = sat_state(
                     {{(SUM_W-STATE_W){z2_ff[STATE_W-1]}}, z2_ff} + term);
                  eso3_pkg::OP_DT_R3: z3_in = sat_state(
                     {{(SUM_W-STATE_W){z3_ff[STATE_W-1]}}, z3_ff} + term);
               endcase
               if (op_ff == eso3_pkg::OP_DT_R3) begin
                  state_in = eso3_pkg::ST_OUT;
               end else begin
                  op_in    = eso3_pkg::op_type'(op_ff + 3'd1);
                  state_in = eso3_pkg::ST_LOAD;
               end
            end
         end
         eso3_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = eso3_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = {z3_ff, z2_ff, z1_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   eso3_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_mag   (mul_a),
      .b_val   (mul_b),
      .status  (mul_st),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= eso3_pkg::ST_IDLE;
         op_ff         <= eso3_pkg::OP_BETA1_ERR;
         rsp_valid_ff  <= 1'b0;
         z1_ff         <= '0;
         z2_ff         <= '0;
         z3_ff         <= '0;
         gain_pos_ff   <= '0;
         gain_spd_ff   <= '0;
         gain_dist_ff  <= '0;
         input_gain_ff <= '0;
         time_step_ff  <= eso3_pkg::TIME_STEP_RESET;
         leak_rate_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         z1_ff         <= z1_in;
         z2_ff         <= z2_in;
         z3_ff         <= z3_in;
         gain_pos_ff   <= gain_pos_in;
         gain_spd_ff   <= gain_spd_in;
         gain_dist_ff  <= gain_dist_in;
         input_gain_ff <= input_gain_in;
         time_step_ff  <= time_step_in;
         leak_rate_ff  <= leak_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      cur_ff      <= cur_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      r3_ff       <= r3_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // multiplier is running or just finished whenever the sequencer waits on it
   `ASSERT_IMPLY(a_mul_active, clock, reset, state_ff == eso3_pkg::ST_MUL, mul_st.busy || mul_st.done, "sequencer waits on idle multiplier")
   `ASSERT_IMPLY(a_done_in_mul, clock, reset, mul_st.done, state_ff == eso3_pkg::ST_MUL, "multiplier result dropped")
   `ASSERT_NEXT(a_accept_start, clock, reset, req_tvalid && req_tready, (state_ff == eso3_pkg::ST_LOAD) && (op_ff == eso3_pkg::OP_BETA1_ERR), "step does not start at first multiply")
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(state_ff) == eso3_pkg::ST_OUT, "result beat raised outside output stage")

endmodule
